// ===== design/rfclm_pkg.sv =====
// shared types and constants for the remote frame checker link monitor
// no dependencies
package rfclm_pkg;

  localparam int PacketBytesDef = 32;
  localparam int WordFirst      = 3;
  localparam int FlagFirst      = 11;
  localparam int SumBytes       = 13;
  localparam int CarriedLast    = 16;
  localparam int WordCount      = 4;
  localparam int FlagCount      = 2;
  localparam int SumW           = 12;
  localparam int CarriedW       = 32;
  localparam int CfgIndexW      = 8;
  localparam int CfgDataW       = 8;

  localparam logic [7:0] LimitReset = 8'd4;

  typedef enum logic [CfgIndexW-1:0] {
    REG_HEADER_FIRST  = 8'd0,
    REG_HEADER_SECOND = 8'd1,
    REG_HEADER_THIRD  = 8'd2,
    REG_FAILURE_LIMIT = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic fire;
    logic good;
  } frame_evt_t;

  typedef struct packed {
    logic [WordCount-1:0][15:0] words;
    logic [FlagCount-1:0][7:0]  flags;
  } staged_t;

endpackage

// ===== design/rfclm_parse.sv =====
// per-byte frame tracker: position, header check, running and carried sums, staging
// depends on rfclm_pkg
module rfclm_parse #(
  parameter int PACKET_BYTES = rfclm_pkg::PacketBytesDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 command,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           header_first,
  input  logic [7:0]           header_second,
  input  logic [7:0]           header_third,
  output rfclm_pkg::frame_evt_t evt,
  output rfclm_pkg::staged_t   staged
);
  import rfclm_pkg::*;

  localparam int PosW = $clog2(PACKET_BYTES);

  logic [PosW-1:0]     pos, pos_next;
  logic [SumW-1:0]     running_sum, running_sum_next;
  logic [CarriedW-1:0] carried_sum, carried_sum_next;
  logic                header_bad, header_bad_next;
  staged_t             staged_next;
  logic [PosW-1:0]     word_off;
  logic [PosW-1:0]     flag_off;
  logic [CarriedW-1:0] carried_shift;

  assign word_off      = pos - PosW'(WordFirst);
  assign flag_off      = pos - PosW'(FlagFirst);
  assign carried_shift = {carried_sum[CarriedW-9:0], data_byte};

  always_comb begin
    pos_next         = pos;
    running_sum_next = running_sum;
    carried_sum_next = carried_sum;
    header_bad_next  = header_bad;
    staged_next      = staged;
    evt              = '0;
    if (take) begin
      if (command) begin
        evt.fire         = 1'b1;
        evt.good         = 1'b0;
        pos_next         = '0;
        running_sum_next = '0;
        carried_sum_next = '0;
        header_bad_next  = 1'b0;
      end else begin
        priority if (pos == PosW'(0)) begin
          if (data_byte == 8'd0 || data_byte != header_first) header_bad_next = 1'b1;
        end else if (pos == PosW'(1)) begin
          if (data_byte != header_second) header_bad_next = 1'b1;
        end else if (pos == PosW'(2)) begin
          if (data_byte != header_third) header_bad_next = 1'b1;
        end else if (pos < PosW'(FlagFirst)) begin
          if (!word_off[0]) begin
            staged_next.words[word_off[2:1]][15:8] = data_byte;
          end else begin
            staged_next.words[word_off[2:1]][7:0] = data_byte;
          end
        end else if (pos < PosW'(SumBytes)) begin
          staged_next.flags[flag_off[0]] = data_byte;
        end else begin
        end

        if (pos < PosW'(SumBytes)) begin
          running_sum_next = running_sum + SumW'(data_byte);
        end else if (pos <= PosW'(CarriedLast)) begin
          carried_sum_next = carried_shift;
        end

        if (pos == PosW'(PACKET_BYTES - 1)) begin
          evt.fire         = 1'b1;
          evt.good         = !header_bad_next &&
                             (CarriedW'(running_sum_next) == carried_sum_next);
          pos_next         = '0;
          running_sum_next = '0;
          carried_sum_next = '0;
          header_bad_next  = 1'b0;
        end else begin
          pos_next = pos + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      running_sum <= '0;
      carried_sum <= '0;
      header_bad  <= 1'b0;
    end else begin
      pos         <= pos_next;
      running_sum <= running_sum_next;
      carried_sum <= carried_sum_next;
      header_bad  <= header_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    staged <= staged_next;
  end

endmodule

// ===== design/rfclm_link.sv =====
// link monitor and result register: failure count, link state, held values
// depends on rfclm_pkg
module rfclm_link (
  input  logic                  clk,
  input  logic                  rst,
  input  rfclm_pkg::frame_evt_t evt,
  input  rfclm_pkg::staged_t    staged,
  input  logic [7:0]            failure_limit,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  frame_status,
  output logic                  link_connected,
  output rfclm_pkg::staged_t    held
);
  import rfclm_pkg::*;

  logic [7:0] failure_count, failure_count_next;
  logic [7:0] count_inc;
  logic       link_up_next;
  staged_t    held_next;
  logic       out_valid_next;

  assign count_inc = failure_count + 8'd1;

  always_comb begin
    failure_count_next = failure_count;
    link_up_next       = link_connected;
    held_next          = held;
    out_valid_next     = out_valid && !out_ready;
    if (evt.fire) begin
      out_valid_next = 1'b1;
      if (evt.good) begin
        held_next          = staged;
        link_up_next       = 1'b1;
        failure_count_next = '0;
      end else if (count_inc == failure_limit) begin
        link_up_next       = 1'b0;
        failure_count_next = '0;
      end else begin
        failure_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_count  <= '0;
      link_connected <= 1'b0;
      held           <= '0;
      out_valid      <= 1'b0;
      frame_status   <= 1'b0;
    end else begin
      failure_count  <= failure_count_next;
      link_connected <= link_up_next;
      held           <= held_next;
      out_valid      <= out_valid_next;
      if (evt.fire) frame_status <= !evt.good;
    end
  end

endmodule

// ===== design/remote_frame_checker_link_monitor.sv =====
// top level of the remote frame checker link monitor: config registers and handshake
// depends on rfclm_pkg, rfclm_parse, rfclm_link
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_ready  | command, data_byte
//  result   | out_valid/ out_ready | frame_status, link_connected, throttle, yaw,
//           |                      | pitch, roll, shutdown_flag, hold_altitude
//  config   | cfg_we               | cfg_index, cfg_data
//
// one word per cycle while in_ready is high; a result shows in the cycle after the word
// that ends a frame or after a no-packet word, set by the single result register
// in_ready drops only while a result waits and out_ready is low
// synchronous reset clears position, sums, held values, failure count and link state
module remote_frame_checker_link_monitor #(
  parameter int PACKET_BYTES = rfclm_pkg::PacketBytesDef
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           frame_status,
  output logic                           link_connected,
  output logic [15:0]                    throttle,
  output logic [15:0]                    yaw,
  output logic [15:0]                    pitch,
  output logic [15:0]                    roll,
  output logic [7:0]                     shutdown_flag,
  output logic [7:0]                     hold_altitude,
  input  logic                           cfg_we,
  input  logic [rfclm_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rfclm_pkg::CfgDataW-1:0]  cfg_data
);
  import rfclm_pkg::*;

  logic [7:0] header_first, header_second, header_third, failure_limit;
  logic       take;
  frame_evt_t evt;
  staged_t    staged;
  staged_t    held;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= '0;
      header_second <= '0;
      header_third  <= '0;
      failure_limit <= LimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        REG_HEADER_THIRD:  header_third  <= cfg_data;
        REG_FAILURE_LIMIT: failure_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rfclm_parse #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .command      (command),
    .data_byte    (data_byte),
    .header_first (header_first),
    .header_second(header_second),
    .header_third (header_third),
    .evt          (evt),
    .staged       (staged)
  );

  rfclm_link u_link (
    .clk           (clk),
    .rst           (rst),
    .evt           (evt),
    .staged        (staged),
    .failure_limit (failure_limit),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .frame_status  (frame_status),
    .link_connected(link_connected),
    .held          (held)
  );

  assign throttle      = held.words[0];
  assign yaw           = held.words[1];
  assign pitch         = held.words[2];
  assign roll          = held.words[3];
  assign shutdown_flag = held.flags[0];
  assign hold_altitude = held.flags[1];

  // a good frame always leaves the link connected
  a_good_means_connected: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_status |-> link_connected)
    else $error("good frame reported with link down");

  // a new result only follows an accepted word
  a_result_from_word: assert property (@(posedge clk) disable iff (rst)
    evt.fire |-> take)
    else $error("frame event without accepted word");

  // a no-packet word always yields a failed result
  a_nopacket_fails: assert property (@(posedge clk) disable iff (rst)
    take && command |=> out_valid && frame_status)
    else $error("no-packet word did not report failure");

  // held values change only with a good frame
  a_held_only_on_good: assert property (@(posedge clk) disable iff (rst)
    !(evt.fire && evt.good) |=> $stable(held))
    else $error("held values changed without good frame");

endmodule
